// ===== rtl/rtts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtts_pkg;

	typedef struct packed {
		logic binary;
		logic hour24;
	} rtts_mode_t;

	typedef enum logic [1:0] {
		CFG_BINARY_MODE,
		CFG_HOUR24_MODE,
		CFG_BOOT_SECONDS
	} rtts_cfg_idx_t;

	typedef struct packed {
		logic [7:0] second;
		logic [7:0] minute;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] year;
	} rtts_dec_t;

	typedef struct packed {
		rtts_dec_t   dec;
		logic [31:0] total;
		logic [31:0] elapsed;
		logic [15:0] up_days;
		logic [4:0]  up_hours;
		logic [5:0]  up_minutes;
		logic [5:0]  up_secs;
	} rtts_res_t;

	localparam logic [28:0] RECIP15 = 29'h1111_1111;
	localparam logic [18:0] RECIP3  = 19'd349525;
	localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [31:0] SEC_PER_DAY = 32'd86400;
	localparam logic [19:0] SEC_PER_HOUR = 20'd3600;
	localparam logic [19:0] SEC_PER_MIN = 20'd60;

	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rtts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtts_front import rtts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rtts_mode_t mode,
	input  logic       push,
	output logic       full,
	input  logic [7:0] raw_second,
	input  logic [7:0] raw_minute,
	input  logic [7:0] raw_hour,
	input  logic [7:0] raw_day,
	input  logic [7:0] raw_month,
	input  logic [7:0] raw_year,
	output logic       dec_valid,
	output rtts_dec_t  dec,
	input  logic       dec_full
);

	function automatic logic [7:0] bcd_decode(input logic [7:0] v);
		return {4'b0, v[3:0]} + {1'b0, v[7:4], 3'b0} + {3'b0, v[7:4], 1'b0};
	endfunction

	logic      vld_s1;
	rtts_dec_t dec_s1;
	rtts_dec_t dec_c;
	logic [7:0] hour_b;
	logic [7:0] hour_m;

	assign full = vld_s1 && dec_full;

	always_comb begin
		if (mode.binary) begin
			dec_c.second = raw_second;
			dec_c.minute = raw_minute;
			hour_b       = raw_hour;
			dec_c.day    = raw_day;
			dec_c.month  = raw_month;
			dec_c.year   = raw_year;
		end else begin
			dec_c.second = bcd_decode(raw_second);
			dec_c.minute = bcd_decode(raw_minute);
			hour_b       = bcd_decode({1'b0, raw_hour[6:0]});
			dec_c.day    = bcd_decode(raw_day);
			dec_c.month  = bcd_decode(raw_month);
			dec_c.year   = bcd_decode(raw_year);
		end
		hour_m = {1'b0, hour_b[6:0]};
		if (hour_m == 8'd12) begin
			hour_m = 8'd0;
		end
		if (raw_hour[7]) begin
			hour_m = hour_m + 8'd12;
		end
		dec_c.hour = mode.hour24 ? hour_b : hour_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			dec_s1 <= dec_c;
		end
	end

	assign dec_valid = vld_s1;
	assign dec       = dec_s1;

endmodule

`default_nettype wire

// ===== rtl/rtts_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtts_queue import rtts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  rtts_dec_t wr_item,
	output logic      q_full,
	input  logic      rd_en,
	output rtts_dec_t rd_item,
	output logic      q_empty
);

	rtts_dec_t  mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign q_full  = (cnt_q == 3'd4);
	assign q_empty = (cnt_q == 3'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rtts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtts_back import rtts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] boot_seconds,
	input  logic        q_empty,
	input  rtts_dec_t   q_item,
	output logic        q_pop,
	output logic        res_empty,
	input  logic        res_pop,
	output rtts_res_t   res
);

	logic [8:0] vld_q;
	logic       adv;

	// Stage 1: day count and time of day.
	rtts_res_t   res_s1;
	logic [16:0] days_s1;
	logic [19:0] hms_s1;
	logic [8:0]  n_p3;
	logic [6:0]  leaps;
	logic [1:0]  c100;
	logic        c400;
	logic [3:0]  m_sat;
	logic [8:0]  mdays;
	logic        leap_adj;
	logic [7:0]  day_add;
	logic [16:0] days_c;
	logic [19:0] hms_c;

	rtts_res_t   res_s2;
	rtts_res_t   res_s3;
	rtts_res_t   res_s4;
	logic [26:0] q1_s4;
	rtts_res_t   res_s5;
	logic [26:0] mtot_s5;
	rtts_res_t   res_s6;
	logic [26:0] mtot_s6;
	logic [20:0] q2_s6;
	rtts_res_t   res_s7;
	logic [20:0] htot_s7;
	rtts_res_t   res_s8;
	logic [20:0] htot_s8;
	logic [15:0] q3_s8;
	rtts_res_t   res_s9;

	rtts_res_t   res_n1;
	rtts_res_t   res_n2;
	rtts_res_t   res_n3;
	rtts_res_t   res_n5;
	rtts_res_t   res_n7;
	rtts_res_t   res_n9;

	logic [29:0] x1;
	logic [58:0] p1;
	logic [30:0] t1;
	logic [30:0] r1;
	logic        c1;
	logic [4:0]  r1_fix;
	logic [24:0] x2;
	logic [53:0] p2;
	logic [25:0] t2;
	logic [25:0] r2;
	logic        c2;
	logic [4:0]  r2_fix;
	logic [17:0] x3;
	logic [36:0] p3;
	logic [18:0] t3;
	logic [18:0] r3;
	logic        c3;
	logic [2:0]  r3_fix;

	rtts_res_t  ofifo_q [2];
	logic       owr_q;
	logic       ord_q;
	logic [1:0] ocnt_q;
	logic       opush;
	logic       opop;

	assign adv   = !vld_q[8] || (ocnt_q != 2'd2);
	assign q_pop = adv && !q_empty;

	always_comb begin
		n_p3  = {1'b0, q_item.year} + 9'd3;
		c400  = (q_item.year != 8'd0);
		if (q_item.year == 8'd0) begin
			c100 = 2'd0;
		end else if (q_item.year <= 8'd100) begin
			c100 = 2'd1;
		end else if (q_item.year <= 8'd200) begin
			c100 = 2'd2;
		end else begin
			c100 = 2'd3;
		end
		leaps = n_p3[8:2] + {6'b0, c400} - {5'b0, c100};
		m_sat = (q_item.month > 8'd12) ? 4'd12 : q_item.month[3:0];
		mdays = (m_sat != 4'd0) ? days_before_month(m_sat - 4'd1) : 9'd0;
		leap_adj = (m_sat > 4'd2) && (q_item.year[1:0] == 2'b00)
			&& (q_item.year != 8'd100) && (q_item.year != 8'd200);
		day_add = (q_item.day != 8'd0) ? (q_item.day - 8'd1) : 8'd0;
		days_c = {9'b0, q_item.year} * DAYS_PER_YEAR + {10'b0, leaps}
			+ {8'b0, mdays} + {16'b0, leap_adj} + {9'b0, day_add};
		hms_c = {12'b0, q_item.hour} * SEC_PER_HOUR + {12'b0, q_item.minute} * SEC_PER_MIN
			+ {12'b0, q_item.second};
	end

	always_comb begin
		x1     = res_s3.elapsed[31:2];
		p1     = {29'b0, x1} * {30'b0, RECIP15};
		t1     = {q1_s4, 4'b0} - {4'b0, q1_s4};
		r1     = {1'b0, res_s4.elapsed[31:2]} - t1;
		c1     = (r1[4:0] >= 5'd15);
		r1_fix = c1 ? (r1[4:0] - 5'd15) : r1[4:0];

		x2     = mtot_s5[26:2];
		p2     = {29'b0, x2} * {25'b0, RECIP15};
		t2     = {1'b0, q2_s6, 4'b0} - {5'b0, q2_s6};
		r2     = {1'b0, mtot_s6[26:2]} - t2;
		c2     = (r2[4:0] >= 5'd15);
		r2_fix = c2 ? (r2[4:0] - 5'd15) : r2[4:0];

		x3     = htot_s7[20:3];
		p3     = {19'b0, x3} * {18'b0, RECIP3};
		t3     = {2'b0, q3_s8, 1'b0} + {3'b0, q3_s8};
		r3     = {1'b0, htot_s8[20:3]} - t3;
		c3     = (r3[2:0] >= 3'd3);
		r3_fix = c3 ? (r3[2:0] - 3'd3) : r3[2:0];
	end

	always_comb begin
		res_n1     = '0;
		res_n1.dec = q_item;

		res_n2       = res_s1;
		res_n2.total = 32'({15'b0, days_s1} * SEC_PER_DAY) + {12'b0, hms_s1};

		res_n3         = res_s2;
		res_n3.elapsed = res_s2.total - boot_seconds;

		res_n5         = res_s4;
		res_n5.up_secs = {r1_fix[3:0], res_s4.elapsed[1:0]};

		res_n7            = res_s6;
		res_n7.up_minutes = {r2_fix[3:0], mtot_s6[1:0]};

		res_n9          = res_s8;
		res_n9.up_hours = {r3_fix[1:0], htot_s8[2:0]};
		res_n9.up_days  = q3_s8 + {15'b0, c3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[7:0], !q_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1  <= res_n1;
			days_s1 <= days_c;
			hms_s1  <= hms_c;

			res_s2 <= res_n2;

			res_s3 <= res_n3;

			res_s4 <= res_s3;
			q1_s4  <= p1[58:32];

			res_s5  <= res_n5;
			mtot_s5 <= q1_s4 + {26'b0, c1};

			res_s6  <= res_s5;
			mtot_s6 <= mtot_s5;
			q2_s6   <= p2[52:32];

			res_s7  <= res_n7;
			htot_s7 <= q2_s6 + {20'b0, c2};

			res_s8  <= res_s7;
			htot_s8 <= htot_s7;
			q3_s8   <= p3[35:20];

			res_s9 <= res_n9;
		end
	end

	assign opush     = adv && vld_q[8];
	assign res_empty = (ocnt_q == 2'd0);
	assign opop      = res_pop && !res_empty;
	assign res       = ofifo_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) begin
				owr_q <= !owr_q;
			end
			if (opop) begin
				ord_q <= !ord_q;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_q[owr_q] <= res_s9;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rtc_time_to_seconds_uptime_core.sv =====
// Decodes one snapshot of raw real-time-clock bytes per transfer into binary calendar
// fields, seconds since 2000-01-01 and the uptime since the boot_seconds register,
// split into days, hours, minutes and seconds. Both sides behave as queues. The block
// sustains one transfer per clock cycle while results are popped as they appear; a result
// passes through the decode stage register, a four-entry queue and a nine-stage arithmetic
// pipeline whose constant divisions are reciprocal multiplies with one correction each,
// ahead of a two-entry result queue. Configuration writes are always ready and must only
// be made while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rtc_time_to_seconds_uptime_core import rtts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  raw_second,
	input  logic [7:0]  raw_minute,
	input  logic [7:0]  raw_hour,
	input  logic [7:0]  raw_day,
	input  logic [7:0]  raw_month,
	input  logic [7:0]  raw_year,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_second,
	output logic [7:0]  out_minute,
	output logic [7:0]  out_hour,
	output logic [7:0]  out_day,
	output logic [7:0]  out_month,
	output logic [7:0]  out_year,
	output logic [31:0] seconds_since_2000,
	output logic [31:0] elapsed_seconds,
	output logic [15:0] up_days,
	output logic [4:0]  up_hours,
	output logic [5:0]  up_minutes,
	output logic [5:0]  up_secs,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	rtts_mode_t  mode_q;
	logic [31:0] boot_q;
	logic        dec_valid;
	rtts_dec_t   dec;
	logic        mq_full;
	logic        mq_empty;
	rtts_dec_t   mq_item;
	logic        mq_pop;
	rtts_res_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q.binary <= 1'b0;
			mode_q.hour24 <= 1'b1;
			boot_q        <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BINARY_MODE:  mode_q.binary <= cfg_data[0];
				CFG_HOUR24_MODE:  mode_q.hour24 <= cfg_data[0];
				CFG_BOOT_SECONDS: boot_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rtts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.push       (push),
		.full       (full),
		.raw_second (raw_second),
		.raw_minute (raw_minute),
		.raw_hour   (raw_hour),
		.raw_day    (raw_day),
		.raw_month  (raw_month),
		.raw_year   (raw_year),
		.dec_valid  (dec_valid),
		.dec        (dec),
		.dec_full   (mq_full)
	);

	rtts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (dec_valid),
		.wr_item (dec),
		.q_full  (mq_full),
		.rd_en   (mq_pop),
		.rd_item (mq_item),
		.q_empty (mq_empty)
	);

	rtts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.boot_seconds (boot_q),
		.q_empty      (mq_empty),
		.q_item       (mq_item),
		.q_pop        (mq_pop),
		.res_empty    (empty),
		.res_pop      (pop),
		.res          (res)
	);

	assign out_second         = res.dec.second;
	assign out_minute         = res.dec.minute;
	assign out_hour           = res.dec.hour;
	assign out_day            = res.dec.day;
	assign out_month          = res.dec.month;
	assign out_year           = res.dec.year;
	assign seconds_since_2000 = res.total;
	assign elapsed_seconds    = res.elapsed;
	assign up_days            = res.up_days;
	assign up_hours           = res.up_hours;
	assign up_minutes         = res.up_minutes;
	assign up_secs            = res.up_secs;

	a_split_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (up_hours < 5'd24) && (up_minutes < 6'd60) && (up_secs < 6'd60))
		else $error("uptime split out of range");

	a_split_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'({16'b0, up_days} * 32'd86400) + {27'b0, up_hours} * 32'd3600
			+ {26'b0, up_minutes} * 32'd60 + {26'b0, up_secs}) == elapsed_seconds)
		else $error("uptime split does not add up to elapsed seconds");

	a_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (elapsed_seconds == seconds_since_2000 - boot_q))
		else $error("elapsed seconds do not match boot base");

endmodule

`default_nettype wire
